[hw/rtl/acla_pkg.sv]
`timescale 1ns / 1ps
// acla_pkg: widths, operation and register codes for the active core limit arbiter
// no dependencies

package acla_pkg;

    localparam int CORE_W    = 7;
    localparam int PERF_W    = 5;
    localparam int OP_W      = 3;
    localparam int TGT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 8;
    localparam int PROD_W    = 14;

    // default core count, loaded into the total and max registers at reset
    localparam int MAX_CORES = 64;

    // ceil(x / 100) as ((x + 99) * RECIP_K) >> RECIP_SH, exact for x below 2^14
    localparam int PERCENT_DIV = 100;
    localparam int RECIP_SH    = 20;
    localparam int RECIP_K     = ((1 << RECIP_SH) + PERCENT_DIV - 1) / PERCENT_DIV;

    localparam logic [OP_W-1:0] OP_LIMIT     = 3'd0;
    localparam logic [OP_W-1:0] OP_UNLIMIT   = 3'd1;
    localparam logic [OP_W-1:0] OP_COMMIT    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CORE_EN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERF_SUP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CORES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACTIVE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_PSTATE = 3'd6;

    typedef logic [CORE_W-1:0] core_cnt_t;

endpackage

[hw/rtl/active_core_limit_arbiter_unit.sv]
`timescale 1ns / 1ps
// active_core_limit_arbiter_unit: top level, per-target request table and commit scan
// depends on acla_pkg
//
// Usage: the s_ channel carries one policy word (op, target, perf index, current
// active count); the m_ channel returns exactly one result word for each.
// Configuration goes through cfg_valid/cfg_index/cfg_data, always ready; the user
// must write it only while no word is in flight, and the block does not enforce this.
// Limit and unlimit take the step product, divide by 100 through a reciprocal,
// then read-modify-write the count memory; commit runs a scan that reads one
// memory entry per cycle through the single read port and one comparator, then
// clamps; clears, unknown ops, out-of-range targets and commits while core_en is
// clear go straight to the result. One word is worked on at a time; s_ready is high
// again from the clock edge that loads the result into the output register.
// A result waiting in the output register blocks only the next load: a new word
// may be accepted and worked on while m_ready is low.
// Reset clears all request valid bits at once (no clearing pass) and loads the
// configuration defaults; the count memory itself is not cleared.

module active_core_limit_arbiter_unit
    import acla_pkg::*;
#(
    parameter int TARGETS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CORE_W-1:0]     cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [TGT_W-1:0]      s_target,
    input  logic [PERF_W-1:0]     s_perf_index,
    input  logic [CORE_W-1:0]     s_current_active,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic [CORE_W-1:0]     m_core_count,
    output logic                  m_apply_setting
);

    localparam int IDX_W  = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam int CNT_W  = $clog2(TARGETS + 1);
    localparam int EXT_W  = 9;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_STEP  = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // configuration
    logic              core_en_reg;
    logic              perf_sup_reg;
    logic [CORE_W-1:0] step_pct_reg;
    logic [CORE_W-1:0] total_reg;
    logic [CORE_W-1:0] min_reg;
    logic [CORE_W-1:0] max_reg;
    logic [PERF_W-1:0] start_reg;

    // control
    logic [2:0]         state_reg, state_next;
    logic [TARGETS-1:0] valid_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic               pipe_reg;
    logic               any_reg;
    logic               m_valid_reg;

    // payload
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic [PERF_W-1:0]  perf_reg;
    core_cnt_t          cur_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               pipe_vld_reg;
    core_cnt_t          lowest_reg;
    logic               res_acc_reg;
    core_cnt_t          res_cnt_reg;
    logic               res_apply_reg;
    logic               out_acc_reg;
    core_cnt_t          out_cnt_reg;
    logic               out_apply_reg;

    // count memory
    core_cnt_t          cnt_mem [TARGETS];
    core_cnt_t          rd_data_reg;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;
    logic               mem_we;

    logic               in_acc;
    logic [EXT_W-1:0]   tgt_ext;
    logic [IDX_W-1:0]   tgt_idx;
    logic               in_range;
    logic               out_free;

    core_cnt_t          req;
    logic               perf_ok;
    logic [EXT_W-1:0]   lim_floor;
    logic               lim_ok;
    core_cnt_t          lim_val;
    logic [EXT_W-1:0]   unl_sum;
    logic               unl_ok;
    core_cnt_t          unl_val;
    logic               apply_ok;
    core_cnt_t          apply_val;
    logic [PROD_W:0]    prod_bias;
    logic [PROD_W+RECIP_SH:0] recip_prod;
    core_cnt_t          low_pre;
    core_cnt_t          low_min;
    core_cnt_t          low_fin;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign tgt_ext  = EXT_W'(s_target);
    assign tgt_idx  = tgt_ext[IDX_W-1:0];
    assign in_range = tgt_ext < EXT_W'(TARGETS);

    assign m_valid         = m_valid_reg;
    assign m_accepted      = out_acc_reg;
    assign m_core_count    = out_cnt_reg;
    assign m_apply_setting = out_apply_reg;

    // ceil(product / 100) by reciprocal
    assign prod_bias  = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(PERCENT_DIV - 1);
    assign recip_prod = (PROD_W + RECIP_SH + 1)'(prod_bias)
                      * (PROD_W + RECIP_SH + 1)'(RECIP_K);

    // limit / unlimit on the entry read back
    always_comb begin
        req       = valid_reg[tgt_reg] ? rd_data_reg : max_reg;
        perf_ok   = !perf_sup_reg || (perf_reg >= start_reg);
        lim_floor = EXT_W'(min_reg) + EXT_W'(step_reg);
        lim_ok    = core_en_reg && perf_ok && (req > min_reg);
        lim_val   = (EXT_W'(req) >= lim_floor) ? CORE_W'(EXT_W'(req) - EXT_W'(step_reg))
                                               : min_reg;
        unl_sum   = EXT_W'(req) + EXT_W'(step_reg);
        unl_ok    = core_en_reg && (req < max_reg);
        unl_val   = (unl_sum < EXT_W'(max_reg)) ? unl_sum[CORE_W-1:0] : max_reg;
        if (op_reg == OP_LIMIT) begin
            apply_ok  = lim_ok;
            apply_val = lim_val;
        end else begin
            apply_ok  = unl_ok;
            apply_val = unl_val;
        end
    end

    // commit clamp, crossed bounds end at max
    always_comb begin
        low_pre = any_reg ? lowest_reg : cur_reg;
        low_min = (low_pre < min_reg) ? min_reg : low_pre;
        low_fin = (low_min > max_reg) ? max_reg : low_min;
    end

    // memory port control
    always_comb begin
        mem_re = 1'b0;
        mem_ra = tgt_idx;
        if (in_acc) begin
            mem_re = 1'b1;
        end else if (state_reg == ST_SCAN && scan_reg < CNT_W'(TARGETS)) begin
            mem_re = 1'b1;
            mem_ra = scan_reg[IDX_W-1:0];
        end
        mem_we = (state_reg == ST_APPLY) && apply_ok;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[tgt_reg] <= apply_val;
        end
        if (mem_re) begin
            rd_data_reg <= cnt_mem[mem_ra];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((s_op == OP_LIMIT || s_op == OP_UNLIMIT) && in_range) begin
                        state_next = ST_STEP;
                    end else if (s_op == OP_COMMIT && core_en_reg) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_STEP:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_reg == CNT_W'(TARGETS)) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            scan_reg     <= '0;
            pipe_reg     <= 1'b0;
            any_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            core_en_reg  <= 1'b0;
            perf_sup_reg <= 1'b0;
            step_pct_reg <= CORE_W'(10);
            total_reg    <= CORE_W'(MAX_CORES);
            min_reg      <= CORE_W'(1);
            max_reg      <= CORE_W'(MAX_CORES);
            start_reg    <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_CORE_EN:      core_en_reg  <= cfg_data[0];
                    REG_PERF_SUP:     perf_sup_reg <= cfg_data[0];
                    REG_STEP_PERCENT: step_pct_reg <= cfg_data;
                    REG_TOTAL_CORES:  total_reg    <= cfg_data;
                    REG_MIN_ACTIVE:   min_reg      <= cfg_data;
                    REG_MAX_ACTIVE:   max_reg      <= cfg_data;
                    REG_START_PSTATE: start_reg    <= cfg_data[PERF_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                scan_reg <= '0;
                pipe_reg <= 1'b0;
                any_reg  <= 1'b0;
                if (s_op == OP_CLEAR && in_range) begin
                    valid_reg[tgt_idx] <= 1'b0;
                end else if (s_op == OP_CLEAR_ALL) begin
                    valid_reg <= '0;
                end
            end

            if (mem_we) begin
                valid_reg[tgt_reg] <= 1'b1;
            end

            if (state_reg == ST_SCAN) begin
                if (scan_reg < CNT_W'(TARGETS)) begin
                    scan_reg <= scan_reg + CNT_W'(1);
                    pipe_reg <= 1'b1;
                end else begin
                    pipe_reg <= 1'b0;
                end
                if (pipe_reg && pipe_vld_reg) begin
                    any_reg <= 1'b1;
                end
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg        <= s_op;
            tgt_reg       <= tgt_idx;
            perf_reg      <= s_perf_index;
            cur_reg       <= s_current_active;
            prod_reg      <= PROD_W'(step_pct_reg) * PROD_W'(total_reg);
            res_acc_reg   <= 1'b0;
            res_cnt_reg   <= '0;
            res_apply_reg <= 1'b0;
        end

        if (state_reg == ST_STEP) begin
            step_reg <= recip_prod[RECIP_SH +: STEP_W];
        end

        if (state_reg == ST_APPLY) begin
            res_acc_reg <= apply_ok;
            res_cnt_reg <= apply_ok ? apply_val : req;
        end

        if (state_reg == ST_SCAN) begin
            if (scan_reg < CNT_W'(TARGETS)) begin
                pipe_vld_reg <= valid_reg[scan_reg[IDX_W-1:0]];
            end
            // data of the entry read last cycle arrives now
            if (pipe_reg && pipe_vld_reg && (!any_reg || rd_data_reg < lowest_reg)) begin
                lowest_reg <= rd_data_reg;
            end
        end

        if (state_reg == ST_CLAMP) begin
            res_cnt_reg   <= low_fin;
            res_acc_reg   <= (low_fin != cur_reg);
            res_apply_reg <= (low_fin != cur_reg);
        end

        if (state_reg == ST_DONE && out_free) begin
            out_acc_reg   <= res_acc_reg;
            out_cnt_reg   <= res_cnt_reg;
            out_apply_reg <= res_apply_reg;
        end
    end

`ifndef SYNTHESIS
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_op == OP_CLEAR_ALL) |=> (valid_reg == '0))
        else $error("request table not empty after clear all");

    a_apply_implies_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_apply_setting) |-> m_accepted)
        else $error("apply_setting without accepted");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_reg <= CNT_W'(TARGETS)))
        else $error("commit scan ran past the table");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && s_ready))
        else $error("result not presented on completion");
`endif

endmodule
